@@ sv/stable_max_priority_queue_macros.svh @@
// Assertion macros shared by the checker of the priority queue.
`ifndef STABLE_MAX_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_MAX_PRIORITY_QUEUE_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define SPQ_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// Checks a consequent in the cycle after its antecedent.
`define SPQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

@@ sv/spq_pkg.sv @@
// Package with the types and codes of the stable max priority queue.
package spq_pkg;

  localparam logic       KIND_ENQUEUE = 1'b0;
  localparam logic       KIND_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_ENQUEUED  = 2'd0;
  localparam logic [1:0] ST_SERVED    = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  priority_req;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  served_priority;
    logic [31:0] served_payload;
    logic [4:0]  occupancy;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT,
    S_PUBLISH
  } state_t;

  typedef struct packed {
    logic load_req;
    logic enq_write;
    logic set_full;
    logic set_empty;
    logic scan_start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic serve_done;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic empty;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage

@@ sv/stable_max_priority_queue.sv @@
// Priority queue that holds up to CAPACITY entries in arrival order and serves
// the oldest entry of greatest priority. One request is handled at a time. An
// enqueue, or a dequeue that finds the queue empty, goes from the decode state
// straight to the publish state before the next request is accepted. A dequeue
// reads the stored entries one per cycle through the single read port of the
// entry memory, first to find the greatest priority and then to close the gap
// behind the served entry. A finished result waits in the output register
// while the next request is accepted and worked on.
module stable_max_priority_queue #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spq_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output spq_pkg::rsp_t out_data
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  spq_datapath #(
    .CAPACITY     (CAPACITY),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ sv/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/spq_datapath.sv @@
// Datapath of the priority queue: entry memory, count, scan and result registers.
module spq_datapath #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spq_pkg::req_t in_data,
  input  spq_pkg::cmd_t cmd,
  output spq_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output spq_pkg::rsp_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = PRIORITY_BITS;
  localparam int EW = PW + 32;

  spq_pkg::req_t req_r;
  spq_pkg::rsp_t res_r;
  spq_pkg::rsp_t out_data_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [AW-1:0] ptr_r;
  logic [AW-1:0] best_idx_r;
  logic [PW-1:0] best_prio_r;
  logic [31:0]   best_pay_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [PW-1:0] rd_prio;
  logic [31:0]   rd_pay;

  logic [PW+7:0] req_prio_ext;
  logic [PW-1:0] req_prio;
  logic [PW+7:0] best_prio_ext;
  logic [CW+4:0] occ_ext;
  logic [CW-1:0] ptr_plus1;

  spq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_prio       = rd_data[EW-1:32];
  assign rd_pay        = rd_data[31:0];
  assign req_prio_ext  = {PW'(0), req_r.priority_req};
  assign req_prio      = req_prio_ext[PW-1:0];
  assign best_prio_ext = {8'd0, best_prio_r};
  assign occ_ext       = {5'd0, count_nxt};
  assign ptr_plus1     = CW'(ptr_r) + CW'(1);

  always_comb begin
    sts.kind       = req_r.kind;
    sts.full       = (count_r == CW'(CAPACITY));
    sts.empty      = (count_r == '0);
    sts.scan_last  = (ptr_plus1 == count_r);
    sts.shift_last = (ptr_plus1 >= count_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq_write) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.serve_done) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    wr_en   = cmd.enq_write || cmd.shift_step;
    wr_addr = ptr_r;
    wr_data = rd_data;
    if (cmd.enq_write) begin
      wr_addr = count_r[AW-1:0];
      wr_data = {req_prio, req_r.payload};
    end
  end

  always_comb begin
    rd_addr = ptr_r;
    if (cmd.scan_start) begin
      rd_addr = '0;
    end else if (cmd.scan_step) begin
      rd_addr = ptr_r + AW'(1);
    end else if (cmd.shift_start) begin
      rd_addr = best_idx_r + AW'(1);
    end else if (cmd.shift_step) begin
      rd_addr = ptr_r + AW'(2);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.scan_start) begin
      ptr_r <= '0;
    end else if (cmd.scan_step || cmd.shift_step) begin
      ptr_r <= ptr_r + AW'(1);
    end else if (cmd.shift_start) begin
      ptr_r <= best_idx_r;
    end
    if (cmd.scan_step && ((ptr_r == '0) || (rd_prio > best_prio_r))) begin
      best_idx_r  <= ptr_r;
      best_prio_r <= rd_prio;
      best_pay_r  <= rd_pay;
    end
    if (cmd.enq_write) begin
      res_r <= '{status: spq_pkg::ST_ENQUEUED, served_priority: 8'd0,
                 served_payload: 32'd0, occupancy: occ_ext[4:0]};
    end else if (cmd.set_full) begin
      res_r <= '{status: spq_pkg::ST_FULL, served_priority: 8'd0,
                 served_payload: 32'd0, occupancy: occ_ext[4:0]};
    end else if (cmd.set_empty) begin
      res_r <= '{status: spq_pkg::ST_EMPTY, served_priority: 8'd0,
                 served_payload: 32'd0, occupancy: occ_ext[4:0]};
    end else if (cmd.serve_done) begin
      res_r <= '{status: spq_pkg::ST_SERVED, served_priority: best_prio_ext[7:0],
                 served_payload: best_pay_r, occupancy: occ_ext[4:0]};
    end
    if (cmd.publish) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/spq_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spq_pkg::sts_t sts,
  output spq_pkg::cmd_t cmd
);

  spq_pkg::state_t state_r;
  spq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = spq_pkg::S_DECODE;
        end
      end
      spq_pkg::S_DECODE: begin
        if (sts.kind == spq_pkg::KIND_DEQUEUE && !sts.empty) begin
          state_nxt = spq_pkg::S_SCAN;
        end else begin
          state_nxt = spq_pkg::S_PUBLISH;
        end
      end
      spq_pkg::S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = spq_pkg::S_SHIFT_START;
        end
      end
      spq_pkg::S_SHIFT_START: begin
        state_nxt = spq_pkg::S_SHIFT;
      end
      spq_pkg::S_SHIFT: begin
        if (sts.shift_last) begin
          state_nxt = spq_pkg::S_PUBLISH;
        end
      end
      spq_pkg::S_PUBLISH: begin
        if (sts.out_free) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      spq_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_req = in_valid;
      end
      spq_pkg::S_DECODE: begin
        if (sts.kind == spq_pkg::KIND_ENQUEUE) begin
          cmd.set_full  = sts.full;
          cmd.enq_write = !sts.full;
        end else begin
          cmd.set_empty  = sts.empty;
          cmd.scan_start = !sts.empty;
        end
      end
      spq_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      spq_pkg::S_SHIFT_START: begin
        cmd.shift_start = 1'b1;
      end
      spq_pkg::S_SHIFT: begin
        cmd.serve_done = sts.shift_last;
        cmd.shift_step = !sts.shift_last;
      end
      spq_pkg::S_PUBLISH: begin
        cmd.publish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ sv/spq_checker.sv @@
// Port checker for the priority queue and its bind to the top level.
`include "stable_max_priority_queue_macros.svh"

module spq_port_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input spq_pkg::rsp_t out_data
);

  logic empty_out;
  logic unserved_out;
  logic fields_zero;

  assign empty_out    = out_valid && (out_data.status == spq_pkg::ST_EMPTY);
  assign unserved_out = out_valid && (out_data.status != spq_pkg::ST_SERVED);
  assign fields_zero  = (out_data.served_priority == 8'd0) &&
                        (out_data.served_payload == 32'd0);

  `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SPQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
  `SPQ_ASSERT_NOW(a_empty_occ, empty_out, out_data.occupancy == 5'd0)
  `SPQ_ASSERT_NOW(a_unserved_zero, unserved_out, fields_zero)

endmodule

bind stable_max_priority_queue spq_port_checker u_spq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ sim/spq_checker.sv @@
// Checker that predicts and compares every result of the stable max priority queue.
`timescale 1ns / 100ps

module spq_checker #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  spq_pkg::req_t in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  spq_pkg::rsp_t out_data,
  output int            fail_count,
  output int            pending_count
);

  localparam logic [7:0] PRIO_MASK = 8'((64'd1 << PRIORITY_BITS) - 1);

  logic [7:0]    slot_prio [CAPACITY];
  logic [31:0]   slot_tag  [CAPACITY];
  int            slot_count;
  spq_pkg::rsp_t expected_rsp_q [$];
  spq_pkg::rsp_t want_rsp;

  function automatic spq_pkg::rsp_t serve_or_store(spq_pkg::req_t req);
    spq_pkg::rsp_t rsp;
    int            best;
    rsp = '0;
    if (req.kind == spq_pkg::KIND_ENQUEUE) begin
      if (slot_count >= CAPACITY) begin
        rsp.status = spq_pkg::ST_FULL;
      end else begin
        slot_prio[slot_count] = req.priority_req & PRIO_MASK;
        slot_tag[slot_count]  = req.payload;
        slot_count++;
        rsp.status = spq_pkg::ST_ENQUEUED;
      end
    end else if (slot_count == 0) begin
      rsp.status = spq_pkg::ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < slot_count; i++) begin
        if (slot_prio[i] > slot_prio[best]) best = i;
      end
      rsp.served_priority = slot_prio[best];
      rsp.served_payload  = slot_tag[best];
      for (int i = best; i + 1 < slot_count; i++) begin
        slot_prio[i] = slot_prio[i + 1];
        slot_tag[i]  = slot_tag[i + 1];
      end
      slot_count--;
      rsp.status = spq_pkg::ST_SERVED;
    end
    rsp.occupancy = 5'(slot_count);
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_count = 0;
      expected_rsp_q.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (out_data.status !== want_rsp.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want_rsp.status, out_data.status);
            fail_count++;
          end
          if (out_data.served_priority !== want_rsp.served_priority) begin
            $display("%0t: served_priority mismatch, expected %0d, actual %0d",
                     $time, want_rsp.served_priority, out_data.served_priority);
            fail_count++;
          end
          if (out_data.served_payload !== want_rsp.served_payload) begin
            $display("%0t: served_payload mismatch, expected %h, actual %h",
                     $time, want_rsp.served_payload, out_data.served_payload);
            fail_count++;
          end
          if (out_data.occupancy !== want_rsp.occupancy) begin
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, want_rsp.occupancy, out_data.occupancy);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_rsp_q.push_back(serve_or_store(in_data));
      pending_count = expected_rsp_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top that drives requests into the stable max priority queue and gives the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_ITEMS = 1100;
  localparam int BURST_AT     = 350;
  localparam int BURST_CYCLES = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 80;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  spq_pkg::req_t in_data;
  logic          out_valid;
  logic          out_stall;
  spq_pkg::rsp_t out_data;
  int            fail_count;
  int            pending_count;
  int            sent_count;
  int            idle_cycles;
  logic          quiet_stretch;
  logic          burst_done;

  stable_max_priority_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  spq_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_req(input logic kind, input logic [7:0] prio, input logic [31:0] tag);
    spq_pkg::req_t req;
    req.kind         = kind;
    req.priority_req = prio;
    req.payload      = tag;
    if (!quiet_stretch && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  initial begin
    out_stall  <= 1'b0;
    burst_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!burst_done && sent_count >= BURST_AT) begin
        burst_done = 1'b1;
        out_stall <= 1'b1;
        repeat (BURST_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !quiet_stretch && ($urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         enq_bias;
    logic       kind;
    logic [7:0] prio;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    quiet_stretch <= 1'b0;
    sent_count    = 0;
    enq_bias      = 50;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue, extreme fields, ties on the greatest priority, then fill until full.
    send_req(spq_pkg::KIND_DEQUEUE, 8'hFF, 32'hFFFF_FFFF);
    send_req(spq_pkg::KIND_ENQUEUE, 8'h00, 32'h0000_0000);
    send_req(spq_pkg::KIND_ENQUEUE, 8'hFF, 32'hFFFF_FFFF);
    send_req(spq_pkg::KIND_DEQUEUE, 8'h00, 32'h0000_0000);
    send_req(spq_pkg::KIND_DEQUEUE, 8'hA5, 32'h5A5A_A5A5);
    send_req(spq_pkg::KIND_ENQUEUE, 8'd7, 32'h0000_00A1);
    send_req(spq_pkg::KIND_ENQUEUE, 8'd7, 32'h0000_00B2);
    send_req(spq_pkg::KIND_ENQUEUE, 8'd5, 32'h0000_00C3);
    send_req(spq_pkg::KIND_ENQUEUE, 8'd7, 32'h0000_00D4);
    send_req(spq_pkg::KIND_DEQUEUE, 8'h00, 32'h0000_0000);
    send_req(spq_pkg::KIND_DEQUEUE, 8'hFF, 32'hFFFF_FFFF);
    repeat (15) send_req(spq_pkg::KIND_ENQUEUE, 8'($urandom_range(255)), $urandom);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) enq_bias = $urandom_range(80, 25);
      quiet_stretch <= (n >= 500 && n < 700);
      kind = ($urandom_range(99) < enq_bias) ? spq_pkg::KIND_ENQUEUE : spq_pkg::KIND_DEQUEUE;
      case ($urandom_range(3))
        0:       prio = 8'($urandom_range(3));
        1:       prio = $urandom_range(1) ? 8'hFF : 8'h00;
        default: prio = 8'($urandom);
      endcase
      send_req(kind, prio, $urandom);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
